>>> rtl/wtr_pkg.sv
// ----------------------------------------------------------------------------
// wtr_pkg
// Shared types and constants for the watchdog timer register unit.
// ----------------------------------------------------------------------------
package wtr_pkg;

	localparam int COUNT_WIDTH_DEFAULT = 32;

	localparam logic [31:0] CMD_START_A = 32'h0000_ff00;
	localparam logic [31:0] CMD_START_B = 32'h0000_00ff;
	localparam logic [31:0] CMD_STOP_A  = 32'h0000_ee00;
	localparam logic [31:0] CMD_STOP_B  = 32'h0000_00ee;

	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_WRITE = 2'd1,
		MODE_READ  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		REG_TIMEOUT = 2'd0,
		REG_COMMAND = 2'd1,
		REG_CAUSE   = 2'd2,
		REG_CONTROL = 2'd3
	} reg_t;

	typedef enum logic [1:0] {
		PHASE_IDLE  = 2'd0,
		PHASE_START = 2'd1,
		PHASE_STOP  = 2'd2
	} phase_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [1:0]  reg_index;
		logic [31:0] write_data;
	} item_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        chip_reset;
		logic        expiry_irq;
		logic        running;
	} result_t;

endpackage

>>> rtl/watchdog_timer_registers_unit.sv
// ----------------------------------------------------------------------------
// watchdog_timer_registers_unit
// Register-mapped watchdog timer with start/stop unlock sequences.
// ----------------------------------------------------------------------------
// Each item (counter tick, register write or register read) produces exactly
// one result. Items are taken into an input register, executed against the
// watchdog state and written to a result register, so the unit sustains one
// item per clock while results are taken; result valid rises when the item
// moves into the result register, which lets a new item enter while the
// previous result waits to be taken. No clearing pass is needed after reset.
module watchdog_timer_registers_unit import wtr_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [1:0]  mode,
	input  logic [1:0]  reg_index,
	input  logic [31:0] write_data,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [31:0] read_data,
	output logic        chip_reset,
	output logic        expiry_irq,
	output logic        running
);

	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t res_s2;
	result_t res_comb;
	logic    advance;

	assign advance    = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item_valid && item_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (result_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= '{mode: mode, reg_index: reg_index, write_data: write_data};
		end
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	wtr_core #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.res    (res_comb)
	);

	assign result_valid = valid_s2;
	assign read_data    = res_s2.read_data;
	assign chip_reset   = res_s2.chip_reset;
	assign expiry_irq   = res_s2.expiry_irq;
	assign running      = res_s2.running;

endmodule

>>> rtl/wtr_core.sv
// ----------------------------------------------------------------------------
// wtr_core
// Watchdog state registers and the combinational execute logic for one item.
// ----------------------------------------------------------------------------
module wtr_core import wtr_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  item_t   item,
	output result_t res
);

	logic [COUNT_WIDTH-1:0] timeout_q, timeout_n;
	logic [COUNT_WIDTH-1:0] down_q, down_n;
	logic                   running_q, running_n;
	phase_t                 phase_q, phase_n;
	logic                   cause_q, cause_n;
	logic                   irq_mode_q, irq_mode_n;

	logic [COUNT_WIDTH+31:0] data_ext;
	logic [COUNT_WIDTH+31:0] tmo_ext;
	logic [COUNT_WIDTH-1:0]  down_dec;
	logic                    expired;

	assign data_ext = {{COUNT_WIDTH{1'b0}}, item.write_data};
	assign tmo_ext  = {32'b0, timeout_q};
	assign down_dec = down_q - COUNT_WIDTH'(1);
	assign expired  = (down_q == '0) || (down_q == COUNT_WIDTH'(1));

	always_comb begin
		timeout_n  = timeout_q;
		down_n     = down_q;
		running_n  = running_q;
		phase_n    = phase_q;
		cause_n    = cause_q;
		irq_mode_n = irq_mode_q;
		res        = '0;
		unique case (item.mode)
			MODE_TICK: begin
				if (running_q) begin
					if (expired) begin
						if (irq_mode_q) begin
							res.expiry_irq = 1'b1;
							down_n         = timeout_q;
						end else begin
							res.chip_reset = 1'b1;
							cause_n        = 1'b1;
							running_n      = 1'b0;
							down_n         = '0;
						end
					end else begin
						down_n = down_dec;
					end
				end
			end
			MODE_WRITE: begin
				unique case (item.reg_index)
					REG_TIMEOUT: timeout_n = data_ext[COUNT_WIDTH-1:0];
					REG_COMMAND: begin
						priority if (item.write_data == CMD_START_A) begin
							phase_n = PHASE_START;
						end else if (item.write_data == CMD_STOP_A) begin
							phase_n = PHASE_STOP;
						end else if (item.write_data == CMD_START_B && phase_q == PHASE_START) begin
							down_n    = timeout_q;
							running_n = 1'b1;
							phase_n   = PHASE_IDLE;
						end else if (item.write_data == CMD_STOP_B && phase_q == PHASE_STOP) begin
							running_n = 1'b0;
							phase_n   = PHASE_IDLE;
						end else begin
							phase_n = PHASE_IDLE;
						end
					end
					REG_CAUSE: begin
						if (item.write_data[0]) begin
							cause_n = 1'b0;
						end
					end
					REG_CONTROL: irq_mode_n = item.write_data[0];
				endcase
			end
			MODE_READ: begin
				unique case (item.reg_index)
					REG_TIMEOUT: res.read_data = tmo_ext[31:0];
					REG_COMMAND: res.read_data = '0;
					REG_CAUSE:   res.read_data = {31'b0, cause_q};
					REG_CONTROL: res.read_data = {31'b0, irq_mode_q};
				endcase
			end
			default: ;
		endcase
		res.running = running_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q  <= '0;
			down_q     <= '0;
			running_q  <= 1'b0;
			phase_q    <= PHASE_IDLE;
			cause_q    <= 1'b0;
			irq_mode_q <= 1'b0;
		end else if (fire) begin
			timeout_q  <= timeout_n;
			down_q     <= down_n;
			running_q  <= running_n;
			phase_q    <= phase_n;
			cause_q    <= cause_n;
			irq_mode_q <= irq_mode_n;
		end
	end

`ifndef SYNTHESIS
	a_reset_pulse_stops: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.chip_reset |=> !running_q && cause_q)
		else $error("chip reset did not stop the counter and set the cause");

	a_irq_reloads: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.expiry_irq |=> running_q && down_q == $past(timeout_q))
		else $error("interrupt expiry did not reload the counter");

	a_single_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> !(res.chip_reset && res.expiry_irq))
		else $error("both expiry pulses set");

	a_stopped_tick_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !running_q && item.mode == MODE_TICK |=> $stable(down_q) && !running_q)
		else $error("tick while stopped changed the counter");

	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.mode == MODE_WRITE && item.reg_index == REG_COMMAND
		&& item.write_data == CMD_START_B && phase_q == PHASE_START
		|=> running_q && phase_q == PHASE_IDLE)
		else $error("completed start sequence did not start the counter");
`endif

endmodule
